// File: src/fpsc_pkg.sv
// Shared types and constants for the frame pacing skip controller.
// No dependencies; every other file in src uses it by scoped names.
package fpsc_pkg;

  localparam logic [3:0]  MAX_SKIPS    = 4'd10;
  localparam logic [5:0]  REF_RATE     = 6'd60;
  localparam logic [19:0] PERIOD_RESET = 20'd16666;  // 1000000 / 60

  localparam logic CFG_FRAME_PERIOD = 1'b0;
  localparam logic CFG_TARGET_FPS   = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] now_us;
  } in_beat_t;

  typedef struct packed {
    logic        skip;
    logic [31:0] wait_us;
  } out_beat_t;

  // Controller to datapath
  typedef struct packed {
    logic resync;
    logic load;
    logic first;
    logic advance;
    logic decide;
    logic div_step;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic started;
    logic late;
    logic div_done;
  } status_t;

endpackage

// File: src/fpsc_datapath.sv
// Datapath: pacing state, configuration registers, shift-free quotient unit
// and result register. Depends on fpsc_pkg.
module fpsc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [19:0]        cfg_data,
  input  fpsc_pkg::in_beat_t in_beat,
  input  fpsc_pkg::cmd_t     cmd,
  output fpsc_pkg::status_t  status,
  output fpsc_pkg::out_beat_t out_beat
);

  logic [19:0] frame_period_us;
  logic [5:0]  target_fps;
  logic        started;
  logic [31:0] deadline_us;
  logic [3:0]  pending_skips;
  logic [5:0]  rate_accum;

  logic [31:0] now_us;
  logic [31:0] rem;
  logic [3:0]  cnt;
  logic        res_skip;
  logic [31:0] res_wait;

  logic [31:0] diff;
  logic [31:0] ahead;
  logic [5:0]  fps;
  logic [19:0] per;
  logic        div_done;
  logic [6:0]  accum_up;

  assign diff     = now_us - deadline_us;
  assign ahead    = deadline_us - now_us;
  assign fps      = (target_fps > fpsc_pkg::REF_RATE) ? fpsc_pkg::REF_RATE : target_fps;
  assign per      = (frame_period_us == 20'd0) ? 20'd1 : frame_period_us;
  assign div_done = (cnt == fpsc_pkg::MAX_SKIPS) || (rem < {12'd0, per});
  assign accum_up = {1'b0, rate_accum} + {1'b0, fpsc_pkg::REF_RATE} - {1'b0, fps};

  assign status.started  = started;
  assign status.late     = (pending_skips == 4'd0) && !diff[31];
  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period_us <= fpsc_pkg::PERIOD_RESET;
      target_fps      <= fpsc_pkg::REF_RATE;
    end else if (cfg_we) begin
      case (cfg_index)
        fpsc_pkg::CFG_FRAME_PERIOD: frame_period_us <= cfg_data;
        fpsc_pkg::CFG_TARGET_FPS:   target_fps      <= cfg_data[5:0];
        default:                    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      deadline_us   <= 32'd0;
      pending_skips <= 4'd0;
      rate_accum    <= fpsc_pkg::REF_RATE;
    end else begin
      if (cmd.resync) begin
        started <= 1'b0;
      end
      if (cmd.first) begin
        started     <= 1'b1;
        deadline_us <= now_us;
      end
      if (cmd.advance) begin
        deadline_us <= deadline_us + {12'd0, frame_period_us};
      end
      if (cmd.decide) begin
        if (pending_skips >= fpsc_pkg::MAX_SKIPS) begin
          pending_skips <= 4'd0;
          started       <= 1'b0;
        end else if (pending_skips != 4'd0) begin
          pending_skips <= pending_skips - 4'd1;
        end else if (diff[31]) begin
          if (rate_accum <= fps) begin
            rate_accum <= accum_up[5:0];
          end else begin
            rate_accum <= rate_accum - fps;
          end
        end
      end
      if (cmd.div_step && div_done) begin
        pending_skips <= cnt;
      end
    end
  end

  // Payload and work registers: no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_us <= in_beat.now_us;
    end
    if (cmd.first) begin
      res_skip <= 1'b0;
      res_wait <= 32'd0;
    end
    if (cmd.decide) begin
      rem <= diff;
      cnt <= 4'd0;
      if (pending_skips != 4'd0) begin
        res_skip <= 1'b1;
        res_wait <= 32'd0;
      end else if (diff[31]) begin
        res_wait <= ahead;
        res_skip <= !(rate_accum <= fps);
      end else begin
        res_skip <= 1'b0;
        res_wait <= 32'd0;
      end
    end
    if (cmd.div_step && !div_done) begin
      rem <= rem - {12'd0, per};
      cnt <= cnt + 4'd1;
    end
    if (cmd.emit) begin
      out_beat.skip    <= res_skip;
      out_beat.wait_us <= res_wait;
    end
  end

endmodule

// File: src/fpsc_ctrl.sv
// Controller state machine: sequences one tick through the datapath and
// owns the output valid flag. Depends on fpsc_pkg.
module fpsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fpsc_pkg::status_t status,
  output fpsc_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ADV    = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode) begin
            cmd.resync = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        if (status.started) begin
          cmd.advance = 1'b1;
          state_next  = ST_DECIDE;
        end else begin
          cmd.first  = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = status.late ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/frame_pacing_skip_controller_unit.sv
// Top level of the frame pacing skip controller.
// Depends on fpsc_pkg, fpsc_datapath and fpsc_ctrl.
//
// Usage:
//   Input channel (in_valid/in_ready/in_beat): one beat per emulated frame.
//   mode 0 is a frame tick and yields one output beat; mode 1 is a resync,
//   which clears the started flag and yields nothing.
//   Output channel (out_valid/out_ready/out_beat): skip decision and the
//   number of microseconds the host should wait before the frame.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 = frame period in us, 1 = target fps); write only while idle.
// Timing:
//   A resync is absorbed in the cycle it is accepted. The first tick after
//   reset, resync or a saturated backlog passes through the ADV and EMIT
//   states before out_valid rises; an early or skipped tick passes through
//   ADV, DECIDE and EMIT. A tick on time or late adds the quotient unit
//   (DIV state), which subtracts the frame period once per cycle until the
//   remainder falls below it or MAX_SKIPS skips are counted. The next beat is
//   accepted once the result sits in the output register.
// Reset (rst, synchronous): clears the started flag, the deadline, pending
//   skips, restores the rate accumulator and both registers to defaults.
// Stall: a result waiting on out_ready holds in the output register; the
//   following tick runs and then holds in its emit step until the slot frees.
module frame_pacing_skip_controller_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [19:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  fpsc_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output fpsc_pkg::out_beat_t out_beat
);

  fpsc_pkg::cmd_t    cmd;
  fpsc_pkg::status_t status;

  // Sequence each tick: latch, advance deadline, decide, divide lag, emit
  fpsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_mode   (in_beat.mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold pacing state and compute the beat payload
  fpsc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_beat   (in_beat),
    .cmd       (cmd),
    .status    (status),
    .out_beat  (out_beat)
  );

endmodule

// File: tb/tb.sv
// Self-checking bench for frame_pacing_skip_controller_unit: drives frame ticks and resyncs,
// predicts each render/skip decision, and compares every output beat in order.
// Depends on fpsc_pkg and the RTL under src; reads nothing at run time.
module tb;

  // Input beat modes (the package carries no names for them)
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_RESYNC = 1'b1;

  // Slack after the last expected beat before touching registers
  localparam int SETTLE_CYCLES = 20;
  // Watchdog limit on a quiet stretch with no beat or register write
  localparam int IDLE_LIMIT    = 2000;
  localparam int PHASE_BEATS   = 220;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic                cfg_index = fpsc_pkg::CFG_FRAME_PERIOD;
  logic [19:0]         cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  fpsc_pkg::in_beat_t  in_beat   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  fpsc_pkg::out_beat_t out_beat;

  frame_pacing_skip_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow of the pacing state and registers, kept in step with accepted beats
  logic        sh_started  = 1'b0;
  logic [31:0] sh_deadline = '0;
  logic [3:0]  sh_pending  = '0;
  logic [5:0]  sh_credit   = fpsc_pkg::REF_RATE;
  logic [19:0] sh_period   = fpsc_pkg::PERIOD_RESET;
  logic [5:0]  sh_fps      = fpsc_pkg::REF_RATE;

  fpsc_pkg::out_beat_t decision_q[$];
  int        mismatches  = 0;

  // Sender pacing: bursts of random length, random gaps; steady turns gaps off
  int        burst_left  = 0;
  bit        steady      = 1'b0;
  // Receiver stall pattern: 0 = always ready, 1 = short stalls, 2 = long stalls
  int        rx_mode     = 0;
  int        rx_run      = 0;
  bit        rx_on       = 1'b1;
  int        idle_cycles = 0;

  // Work out the decision for one accepted beat and queue it, if the beat yields one
  task automatic predict_pacing(input fpsc_pkg::in_beat_t b);
    fpsc_pkg::out_beat_t d;
    logic [31:0] lag;
    logic [31:0] per;
    logic [31:0] n;
    logic [5:0]  f;
    d = '0;
    if (b.mode == MODE_RESYNC) begin
      // resync only drops the latch; pending skips and credit survive
      sh_started = 1'b0;
      return;
    end
    if (!sh_started) begin
      sh_started  = 1'b1;
      sh_deadline = b.now_us;
    end else begin
      sh_deadline = sh_deadline + sh_period;
      if (sh_pending >= fpsc_pkg::MAX_SKIPS) begin
        // saturated backlog: skip, flush it and relatch on the next tick
        sh_pending = '0;
        sh_started = 1'b0;
        d.skip     = 1'b1;
      end else if (sh_pending != 0) begin
        sh_pending = sh_pending - 1'b1;
        d.skip     = 1'b1;
      end else begin
        lag = b.now_us - sh_deadline;
        if (lag[31]) begin
          // early: report the wait, thin rendering through the rate credit
          f         = (sh_fps > fpsc_pkg::REF_RATE) ? fpsc_pkg::REF_RATE : sh_fps;
          d.wait_us = sh_deadline - b.now_us;
          if (sh_credit <= f) begin
            sh_credit = sh_credit + fpsc_pkg::REF_RATE - f;
          end else begin
            sh_credit = sh_credit - f;
            d.skip    = 1'b1;
          end
        end else begin
          // late or on time: render and schedule lag / period skips, capped at MAX_SKIPS
          per        = (sh_period == 0) ? 32'd1 : {12'd0, sh_period};
          n          = lag / per;
          sh_pending = (n > fpsc_pkg::MAX_SKIPS) ? fpsc_pkg::MAX_SKIPS : n[3:0];
        end
      end
    end
    decision_q.push_back(d);
  endtask

  // Next deadline the block will compare against (meaningful while latched)
  function automatic logic [31:0] due();
    return sh_deadline + sh_period;
  endfunction

  // Send one beat; hold valid and payload until accepted, then predict
  task automatic send_beat(input logic mode, input logic [31:0] now);
    fpsc_pkg::in_beat_t b;
    if (!steady && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    b.mode   = mode;
    b.now_us = now;
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (!in_ready);
    predict_pacing(b);
  endtask

  // Drop valid, wait for every expected beat, then give the block time to go idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decision_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [19:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == fpsc_pkg::CFG_FRAME_PERIOD) sh_period = data;
    else sh_fps = data[5:0];
  endtask

  // Aim most ticks near the next deadline so the late/early/backlog paths all get hit
  function automatic logic [31:0] pick_now();
    logic [31:0] base;
    logic [31:0] per;
    int          r;
    per  = (sh_period == 0) ? 32'd1 : {12'd0, sh_period};
    base = sh_started ? due() : $urandom;
    r    = $urandom_range(0, 99);
    if (r < 35) return base - $urandom_range(1, per);
    else if (r < 65) return base + $urandom_range(0, per - 1);
    else if (r < 85) return base + $urandom_range(1, 13) * per + $urandom_range(0, per - 1);
    else if (r < 93) return $urandom;
    else return base;
  endfunction

  // Latch, on time, early, late backlog, saturation, wrap and resync at reset registers
  task automatic test_directed_pacing();
    send_beat(MODE_TICK, 32'd1000);
    send_beat(MODE_TICK, due());
    send_beat(MODE_TICK, due() - 32'd500);
    send_beat(MODE_TICK, due() + 3 * fpsc_pkg::PERIOD_RESET + 7);
    repeat (3) send_beat(MODE_TICK, $urandom);
    send_beat(MODE_TICK, due());
    send_beat(MODE_TICK, due() + 25 * fpsc_pkg::PERIOD_RESET);
    send_beat(MODE_TICK, due());
    send_beat(MODE_TICK, 32'hFFFF_FFF0);
    send_beat(MODE_TICK, due());
    send_beat(MODE_TICK, due() - 32'd1);
    send_beat(MODE_RESYNC, 32'hFFFF_FFFF);
    send_beat(MODE_TICK, 32'h0000_0000);
    send_beat(MODE_TICK, due() + 2 * fpsc_pkg::PERIOD_RESET);
    send_beat(MODE_RESYNC, 32'h0000_0000);
    // relatch with the backlog of two still pending
    send_beat(MODE_TICK, 32'h8000_0000);
    send_beat(MODE_TICK, $urandom);
    send_beat(MODE_TICK, $urandom);
    send_beat(MODE_TICK, due());
  endtask

  // Rate extremes on early ticks, then zero and widest frame period
  task automatic test_register_limits();
    write_reg(fpsc_pkg::CFG_TARGET_FPS, 20'd0);
    send_beat(MODE_RESYNC, 32'd0);
    send_beat(MODE_TICK, 32'd5000);
    repeat (3) send_beat(MODE_TICK, due() - 32'd100);
    write_reg(fpsc_pkg::CFG_TARGET_FPS, 20'd63);
    repeat (3) send_beat(MODE_TICK, due() - 32'd1);
    write_reg(fpsc_pkg::CFG_TARGET_FPS, 20'd1);
    repeat (2) send_beat(MODE_TICK, due() - 32'd7);
    write_reg(fpsc_pkg::CFG_FRAME_PERIOD, 20'd0);
    send_beat(MODE_TICK, due() + 32'd50);
    send_beat(MODE_TICK, due());
    write_reg(fpsc_pkg::CFG_FRAME_PERIOD, 20'hFFFFF);
    send_beat(MODE_TICK, 32'hFFFF_FFFF);
    send_beat(MODE_TICK, due() + 2 * 32'hFFFFF + 3);
  endtask

  task automatic test_random_pacing(input int beats);
    repeat (beats) begin
      if ($urandom_range(0, 99) < 4) send_beat(MODE_RESYNC, $urandom);
      else send_beat(MODE_TICK, pick_now());
    end
  endtask

  // Several register settings, extremes included; vary idling per phase
  task automatic test_random_phases();
    logic [19:0] periods[7];
    logic [5:0]  rates[7];
    periods = '{fpsc_pkg::PERIOD_RESET, 20'd1, 20'd0, 20'hFFFFF, 20'd1000, 20'd100, 20'd0};
    rates   = '{fpsc_pkg::REF_RATE, 6'd1, 6'd0, 6'd63, 6'd30, 6'd45, 6'd0};
    periods[6] = 20'($urandom_range(1, 1000000));
    rates[6]   = 6'($urandom_range(0, 63));
    for (int i = 0; i < 7; i++) begin
      write_reg(fpsc_pkg::CFG_FRAME_PERIOD, periods[i]);
      // junk in the upper data bits must be dropped by the rate register
      write_reg(fpsc_pkg::CFG_TARGET_FPS, {14'($urandom), rates[i]});
      rx_mode = i % 3;
      steady  = (i % 4 == 3);
      test_random_pacing(PHASE_BEATS);
    end
  endtask

  // Receiver: advance the stall pattern every cycle
  always @(posedge clk) begin
    if (rx_mode == 0) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_on  = ~rx_on;
        rx_run = rx_on ? $urandom_range(1, 12)
                       : (rx_mode == 1 ? $urandom_range(1, 3) : $urandom_range(5, 30));
      end else begin
        rx_run--;
      end
      out_ready <= rx_on;
    end
  end

  // Compare each accepted output beat with the oldest queued decision
  always @(posedge clk) begin
    fpsc_pkg::out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (decision_q.size() == 0) begin
        $display("%0t: unexpected beat skip=%0b wait_us=%0d", $time,
                 out_beat.skip, out_beat.wait_us);
        mismatches++;
      end else begin
        want = decision_q.pop_front();
        if (out_beat.skip !== want.skip) begin
          $display("%0t: skip expected %0b actual %0b", $time, want.skip, out_beat.skip);
          mismatches++;
        end
        if (out_beat.wait_us !== want.wait_us) begin
          $display("%0t: wait_us expected %0d actual %0d", $time,
                   want.wait_us, out_beat.wait_us);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: drop the run if no beat or register write moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_pacing();
    test_register_limits();
    test_random_phases();
    settle();
    if (mismatches == 0 && decision_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
